// ----- src/markup_tag_stripper_assert.svh -----
// Assertion macros used by the markup tag stripper checker.
`ifndef MARKUP_TAG_STRIPPER_ASSERT_SVH
`define MARKUP_TAG_STRIPPER_ASSERT_SVH

// Checked at every clock edge outside reset.
`define MTS_ASSERT_SYNC(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define MTS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- src/mts_pkg.sv -----
// Types, character constants and helpers for the markup tag stripper.
package mts_pkg;

   localparam logic [7:0] CharLt    = 8'h3C;
   localparam logic [7:0] CharGt    = 8'h3E;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharNone  = 8'h00;
   localparam logic [7:0] CaseBit   = 8'h20;

   localparam logic       LettersOnlyReset = 1'b1;
   localparam logic [2:0] NameLen          = 3'd6;

   typedef enum logic [5:0] {
      PhText  = 6'b000001,
      PhName  = 6'b000010,
      PhTag   = 6'b000100,
      PhSkip  = 6'b001000,
      PhBody  = 6'b010000,
      PhClose = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] char_val;
      logic       pass;
      logic       last;
   } verdict_type;

   // letters of "script", in order
   function automatic logic [7:0] script_letter(input logic [2:0] idx);
      logic [7:0] res;
      case (idx)
         3'd0:    res = 8'h73;
         3'd1:    res = 8'h63;
         3'd2:    res = 8'h72;
         3'd3:    res = 8'h69;
         3'd4:    res = 8'h70;
         3'd5:    res = 8'h74;
         default: res = CharNone;
      endcase
      return res;
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return c inside {[8'h41:8'h5A]};
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      return is_upper(c) ? (c | CaseBit) : c;
   endfunction

endpackage

// ----- src/mts_if.sv -----
// Valid/ready channel interfaces for text bytes, results and the control register.
interface mts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;
   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface mts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       keep;
   logic       out_last;
   modport source (output valid, output out_char, output keep, output out_last, input ready);
   modport sink   (input valid, input out_char, input keep, input out_last, output ready);
endinterface

interface mts_csr_if;
   logic valid;
   logic ready;
   logic letters_only;
   modport source (output valid, output letters_only, input ready);
   modport sink   (input valid, input letters_only, output ready);
endinterface

// ----- src/mts_in_stage.sv -----
// Input register stage of the markup tag stripper.
module mts_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   mts_req_if.sink               req_bus,
   input  logic                  out_free,
   output logic                  item_vld,
   output mts_pkg::req_item_type item
);

   logic                  vld_ff, vld_in;
   mts_pkg::req_item_type item_ff, item_in;
   logic                  take;

   assign req_bus.ready = !vld_ff || out_free;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (req_bus.ready) begin
         vld_in = req_bus.valid;
      end
      if (take) begin
         item_in.in_char = req_bus.in_char;
         item_in.in_last = req_bus.in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule

// ----- src/mts_parser.sv -----
// Tag parser state machine: decides whether each byte lies outside markup.
module mts_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  mts_pkg::req_item_type item,
   output mts_pkg::verdict_type  verdict
);

   mts_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         count_ff, count_in;
   logic [7:0]         c;
   logic               pass;
   logic [2:0]         count_inc;

   assign c         = item.in_char;
   assign count_inc = count_ff + 3'd1;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      pass     = 1'b0;
      case (phase_ff)
         mts_pkg::PhName: begin
            if (count_ff < mts_pkg::NameLen &&
                mts_pkg::fold_lower(c) == mts_pkg::script_letter(count_ff)) begin
               count_in = count_inc;
               if (count_inc == mts_pkg::NameLen) begin
                  phase_in = mts_pkg::PhSkip;
                  count_in = 3'd0;
               end
            end else begin
               count_in = 3'd0;
               phase_in = (c == mts_pkg::CharGt) ? mts_pkg::PhText : mts_pkg::PhTag;
            end
         end
         mts_pkg::PhTag: begin
            if (c == mts_pkg::CharGt) phase_in = mts_pkg::PhText;
         end
         mts_pkg::PhSkip: begin
            phase_in = mts_pkg::PhBody;
         end
         mts_pkg::PhBody: begin
            if (c == mts_pkg::CharLt) phase_in = mts_pkg::PhClose;
         end
         mts_pkg::PhClose: begin
            if (c == mts_pkg::CharGt) phase_in = mts_pkg::PhText;
         end
         default: begin
            if (c == mts_pkg::CharLt) begin
               phase_in = mts_pkg::PhName;
               count_in = 3'd0;
            end else begin
               phase_in = mts_pkg::PhText;
               pass     = 1'b1;
            end
         end
      endcase
      if (item.in_last) begin
         phase_in = mts_pkg::PhText;
         count_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mts_pkg::PhText;
         count_ff <= 3'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   assign verdict.char_val = c;
   assign verdict.pass     = pass;
   assign verdict.last     = item.in_last;

endmodule

// ----- src/mts_out_stage.sv -----
// Letter filter and result register of the markup tag stripper.
module mts_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  mts_pkg::verdict_type verdict,
   input  logic                 letters_only,
   mts_rsp_if.source            rsp_bus,
   output logic                 out_free
);

   logic       vld_ff, vld_in;
   logic [7:0] char_ff, char_in;
   logic       keep_ff, keep_in;
   logic       last_ff, last_in;
   logic [7:0] emit;
   logic       keep;

   always_comb begin
      emit = verdict.char_val;
      keep = verdict.pass;
      if (verdict.pass && letters_only) begin
         if (verdict.char_val == mts_pkg::CharCr || verdict.char_val == mts_pkg::CharLf) begin
            emit = mts_pkg::CharSpace;
         end else if (!(mts_pkg::is_letter(verdict.char_val) ||
                        verdict.char_val == mts_pkg::CharSpace)) begin
            keep = 1'b0;
         end
      end
   end

   assign out_free = !vld_ff || rsp_bus.ready;

   always_comb begin
      vld_in  = vld_ff;
      char_in = char_ff;
      keep_in = keep_ff;
      last_in = last_ff;
      if (out_free) begin
         vld_in = step;
      end
      if (step) begin
         char_in = keep ? emit : mts_pkg::CharNone;
         keep_in = keep;
         last_in = verdict.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      char_ff <= char_in;
      keep_ff <= keep_in;
      last_ff <= last_in;
   end

   assign rsp_bus.valid    = vld_ff;
   assign rsp_bus.out_char = char_ff;
   assign rsp_bus.keep     = keep_ff;
   assign rsp_bus.out_last = last_ff;

endmodule

// ----- src/markup_tag_stripper.sv -----
// Top level of the markup tag stripper: strips tags and script bodies from a byte stream.
//
//   channel   dir   payload                     transfer when
//   req_bus   in    in_char, in_last            valid && ready
//   rsp_bus   out   out_char, keep, out_last    valid && ready
//   csr_bus   in    letters_only                valid && ready
//
// One byte per cycle sustained while rsp is not stalled; each byte passes the
// input register, then parser and filter into the result register.
// Reset clears the parser to text phase and sets letters_only.
// A stalled rsp holds the result; the input register takes one more byte only if it is empty.
// csr_bus is always ready.
module markup_tag_stripper (
   input  logic      clock,
   input  logic      reset,
   mts_req_if.sink   req_bus,
   mts_rsp_if.source rsp_bus,
   mts_csr_if.sink   csr_bus
);

   logic                  letters_ff, letters_in;
   logic                  out_free;
   logic                  item_vld;
   logic                  step;
   mts_pkg::req_item_type item;
   mts_pkg::verdict_type  verdict;

   assign csr_bus.ready = 1'b1;
   assign letters_in    = (csr_bus.valid && csr_bus.ready) ? csr_bus.letters_only : letters_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         letters_ff <= mts_pkg::LettersOnlyReset;
      end else begin
         letters_ff <= letters_in;
      end
   end

   assign step = item_vld && out_free;

   mts_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .out_free (out_free),
      .item_vld (item_vld),
      .item     (item)
   );

   mts_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (item),
      .verdict (verdict)
   );

   mts_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .verdict      (verdict),
      .letters_only (letters_ff),
      .rsp_bus      (rsp_bus),
      .out_free     (out_free)
   );

endmodule

// ----- src/mts_checker.sv -----
// Port-level assertion checker for the markup tag stripper, bound to the top level.
`include "markup_tag_stripper_assert.svh"

module mts_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_keep,
   input logic       rsp_out_last
);

   `MTS_ASSERT_SYNC(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_keep) && $stable(rsp_out_last), "rsp changed while stalled")
   `MTS_ASSERT_SYNC(a_drop_zero, rsp_valid && !rsp_keep |-> rsp_out_char == mts_pkg::CharNone, "dropped byte not zero")
   `MTS_ASSERT_SYNC(a_no_open, rsp_valid && rsp_keep |-> rsp_out_char != mts_pkg::CharLt, "tag open kept")
   `MTS_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_valid, "rsp valid after reset")

endmodule

bind markup_tag_stripper mts_checker u_mts_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_out_char (rsp_bus.out_char),
   .rsp_keep     (rsp_bus.keep),
   .rsp_out_last (rsp_bus.out_last)
);
